/* src/depth_background_subtraction_macros.svh */
// Assertion macros shared by the checker of the depth background subtraction block.
`ifndef DEPTH_BACKGROUND_SUBTRACTION_MACROS_SVH
`define DEPTH_BACKGROUND_SUBTRACTION_MACROS_SVH

// Implication that is switched off while reset is asserted.
`define DBS_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("depth background subtraction check failed");

// Implication that is also checked while reset is asserted.
`define DBS_ASSERT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("depth background subtraction check failed");

// Same-cycle implication that is switched off while reset is asserted.
`define DBS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("depth background subtraction check failed");

`endif

/* src/dbs_pkg.sv */
// Types and constants of the depth background subtraction block.
package dbs_pkg;

  localparam int FRAME_WIDTH_DEF  = 640;
  localparam int FRAME_HEIGHT_DEF = 480;

  localparam int DEPTH_W   = 16;
  localparam int IDX_W     = 19;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_RANGE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RANGE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MARGIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEPT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LEARN     = 3'd4;

  localparam logic [DEPTH_W-1:0] MIN_RANGE_RST = 16'd500;
  localparam logic [DEPTH_W-1:0] MAX_RANGE_RST = 16'd4500;
  localparam logic [DEPTH_W-1:0] MARGIN_RST    = 16'd100;
  localparam logic [DEPTH_W-1:0] ACCEPT_RST    = 16'd30;
  localparam logic [DEPTH_W-1:0] LEARN_RST     = 16'd30;

  localparam logic [DEPTH_W-1:0] COUNT_MAX = 16'hFFFF;

  typedef struct packed {
    logic [DEPTH_W-1:0] min_range_mm;
    logic [DEPTH_W-1:0] max_range_mm;
    logic [DEPTH_W-1:0] margin;
    logic [DEPTH_W-1:0] accept_frames;
    logic [DEPTH_W-1:0] learn_frames;
  } cfg_t;

  typedef struct packed {
    logic [DEPTH_W-1:0] background;
    logic [DEPTH_W-1:0] pending;
  } pix_t;

  localparam int PIX_W = $bits(pix_t);

endpackage

/* src/dbs_mem.sv */
// Per-pixel state memory with one write port and one registered read port.
module dbs_mem
  import dbs_pkg::*;
#(
  parameter int DEPTH = FRAME_WIDTH_DEF * FRAME_HEIGHT_DEF,
  parameter int AW    = $clog2(FRAME_WIDTH_DEF * FRAME_HEIGHT_DEF),
  parameter int DW    = PIX_W
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* src/dbs_update.sv */
// Per-pixel background update and foreground decision.
module dbs_update
  import dbs_pkg::*;
(
  input  cfg_t               cfg,
  input  logic               was_ready,
  input  logic [DEPTH_W-1:0] depth,
  input  pix_t               cur,
  output pix_t               nxt,
  output logic               fg
);

  logic [DEPTH_W:0]   depth_plus_margin;
  logic               far;
  logic [DEPTH_W-1:0] pend_inc;
  logic [DEPTH_W-1:0] bg_max;

  always_comb begin
    depth_plus_margin = {1'b0, depth} + {1'b0, cfg.margin};
    far = (depth_plus_margin >= {1'b0, cur.background}) || (cur.background == '0);
    pend_inc = (cur.pending != COUNT_MAX) ? cur.pending + 1'b1 : cur.pending;
    bg_max = (depth > cur.background) ? depth : cur.background;
    nxt = cur;
    if (depth != '0) begin
      if (!was_ready) begin
        nxt.background = bg_max;
      end else if (far) begin
        nxt.background = bg_max;
        nxt.pending = (cur.pending != '0) ? cur.pending - 1'b1 : cur.pending;
      end else if (pend_inc >= cfg.accept_frames) begin
        nxt.background = depth;
        nxt.pending = '0;
      end else begin
        nxt.pending = pend_inc;
      end
    end
    fg = was_ready && (depth >= cfg.min_range_mm) && (depth <= cfg.max_range_mm) &&
         (nxt.background != '0) && (depth_plus_margin < {1'b0, nxt.background});
  end

endmodule

/* src/depth_background_subtraction.sv */
// Top level of the depth background subtraction block.
//
// Depth pixels enter on the in_ stream: in_tdata carries the depth in millimetres and the
// raster index, in_tlast marks the final pixel of a frame. Each pixel gives exactly one
// item on the out_ stream: out_tdata bit 0 is the foreground flag, out_tuser tells
// whether the background model had finished learning when the pixel was processed.
// Registers are written through the cfg_ port, which is always ready; write them only
// while no pixel is in flight.
// One pixel is accepted per cycle while the memory sweep is over and the receiver does not
// hold back the out_ stream. The state memory read and the input registers share the
// accepting edge; the update result is then loaded into the output register once it is free.
// The throughput is set by the single read port and single write port of the state
// memory; a pixel that hits the index of the one before it is served by forwarding.
// After reset the memory is swept to zero, one entry per cycle, over all
// FRAME_WIDTH*FRAME_HEIGHT entries (307200 by default); in_tready stays low meanwhile.
// When the receiver holds out_tready low, the result waits in the output register, one
// more pixel is taken into the update stage and then in_tready drops until space frees.
module depth_background_subtraction
  import dbs_pkg::*;
#(
  parameter int FRAME_WIDTH  = FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = FRAME_HEIGHT_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [39:0]          in_tdata,   // depth_value, pixel_index, zero fill
  input  logic                 in_tlast,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [7:0]           out_tdata,  // is_foreground, zero fill
  output logic                 out_tuser,  // model_ready
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DEPTH_W-1:0]   cfg_data
);

  localparam int PIXEL_COUNT = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int AW = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;

  cfg_t                 cfg_r;
  logic                 clr_busy_r;
  logic [AW-1:0]        clr_cnt_r;
  logic                 s1_valid_r;
  logic [DEPTH_W-1:0]   s1_depth_r;
  logic [AW-1:0]        s1_addr_r;
  logic                 s1_inrange_r;
  logic                 s1_ready_r;
  logic                 fwd_hit_r;
  pix_t                 fwd_data_r;
  logic                 ready_flag_r;
  logic                 ready_flag_nxt;
  logic [DEPTH_W-1:0]   learned_r;
  logic [DEPTH_W-1:0]   learned_nxt;
  logic                 out_valid_r;
  logic                 out_fg_r;
  logic                 out_rdy_r;

  logic [DEPTH_W-1:0]   in_depth;
  logic [31:0]          in_idx_ext;
  logic [AW-1:0]        in_addr;
  logic                 in_inrange;
  logic                 in_acc;
  logic                 s1_adv;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [PIX_W-1:0]     mem_wdata;
  logic [PIX_W-1:0]     mem_rdata;
  pix_t                 cur_pix;
  pix_t                 upd_pix;
  logic                 upd_fg;

  assign in_depth   = in_tdata[DEPTH_W-1:0];
  assign in_idx_ext = 32'(in_tdata[DEPTH_W+IDX_W-1:DEPTH_W]);
  assign in_addr    = in_idx_ext[AW-1:0];
  assign in_inrange = in_idx_ext < 32'(PIXEL_COUNT);

  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !clr_busy_r && (!s1_valid_r || s1_adv);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign cur_pix = fwd_hit_r ? fwd_data_r : pix_t'(mem_rdata);

  dbs_update u_update (
    .cfg       (cfg_r),
    .was_ready (s1_ready_r),
    .depth     (s1_depth_r),
    .cur       (cur_pix),
    .nxt       (upd_pix),
    .fg        (upd_fg)
  );

  assign mem_we    = clr_busy_r || (s1_adv && s1_inrange_r);
  assign mem_waddr = clr_busy_r ? clr_cnt_r : s1_addr_r;
  assign mem_wdata = clr_busy_r ? '0 : PIX_W'(upd_pix);

  dbs_mem #(
    .DEPTH (PIXEL_COUNT),
    .AW    (AW),
    .DW    (PIX_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (in_acc && in_inrange),
    .raddr (in_addr),
    .rdata (mem_rdata)
  );

  always_comb begin
    learned_nxt    = learned_r;
    ready_flag_nxt = ready_flag_r;
    if (in_acc && !ready_flag_r && in_tlast) begin
      learned_nxt = (learned_r != COUNT_MAX) ? learned_r + 1'b1 : learned_r;
      if (learned_nxt >= cfg_r.learn_frames) begin
        ready_flag_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_range_mm  <= MIN_RANGE_RST;
      cfg_r.max_range_mm  <= MAX_RANGE_RST;
      cfg_r.margin        <= MARGIN_RST;
      cfg_r.accept_frames <= ACCEPT_RST;
      cfg_r.learn_frames  <= LEARN_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MIN_RANGE: cfg_r.min_range_mm  <= cfg_data;
        REG_MAX_RANGE: cfg_r.max_range_mm  <= cfg_data;
        REG_MARGIN:    cfg_r.margin        <= cfg_data;
        REG_ACCEPT:    cfg_r.accept_frames <= cfg_data;
        REG_LEARN:     cfg_r.learn_frames  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clr_busy_r) begin
      if (32'(clr_cnt_r) == PIXEL_COUNT - 1) begin
        clr_busy_r <= 1'b0;
      end else begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      fwd_hit_r    <= 1'b0;
      ready_flag_r <= 1'b0;
      learned_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      ready_flag_r <= ready_flag_nxt;
      learned_r    <= learned_nxt;
      if (in_acc) begin
        s1_valid_r <= 1'b1;
        fwd_hit_r  <= s1_adv && s1_inrange_r && in_inrange && (in_addr == s1_addr_r);
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_depth_r   <= in_depth;
      s1_addr_r    <= in_addr;
      s1_inrange_r <= in_inrange;
      s1_ready_r   <= ready_flag_r;
      fwd_data_r   <= upd_pix;
    end
    if (s1_adv) begin
      out_fg_r  <= upd_fg && s1_inrange_r;
      out_rdy_r <= s1_ready_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_fg_r};
  assign out_tuser  = out_rdy_r;

endmodule

/* src/dbs_checker.sv */
// Port-level checker of the depth background subtraction block and its bind.
`include "depth_background_subtraction_macros.svh"

module dbs_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tuser
);

  logic [8:0] out_word;

  assign out_word = {out_tuser, out_tdata};

  `DBS_ASSERT_RST(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_word))
  `DBS_ASSERT_NOW(a_fg_needs_ready, out_tvalid && out_tdata[0], out_tuser)
  `DBS_ASSERT_RST(a_ready_sticks, out_tvalid && out_tuser, out_tuser)
  `DBS_ASSERT_ALWAYS(a_clear_after_reset, !rst_n, !in_tready)

endmodule

bind depth_background_subtraction dbs_checker u_dbs_checker (.*);

/* sim/depth_background_subtraction_tb.sv */
// Self-checking testbench for the depth background subtraction block.
module depth_background_subtraction_tb
  import dbs_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PIXEL_COUNT = FRAME_WIDTH_DEF * FRAME_HEIGHT_DEF;
  localparam int IDLE_LIMIT  = 3 * PIXEL_COUNT;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 110;
  localparam int PHASES      = 8;

  typedef struct packed {
    logic [DEPTH_W-1:0] depth;
    logic [IDX_W-1:0]   index;
    logic               last;
  } pixel_t;

  typedef struct packed {
    logic fg;
    logic ready;
  } verdict_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [39:0]          in_tdata = '0;   // depth_value, pixel_index, zero fill
  logic                 in_tlast = 1'b0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [7:0]           out_tdata;       // is_foreground, zero fill
  logic                 out_tuser;       // model_ready
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DEPTH_W-1:0]   cfg_data = '0;

  depth_background_subtraction u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Mirror of the block state.
  bit [DEPTH_W-1:0] bg_mem   [PIXEL_COUNT];
  bit [DEPTH_W-1:0] pend_mem [PIXEL_COUNT];
  bit               mirror_ready = 1'b0;
  bit [DEPTH_W-1:0] frames_learned = '0;
  cfg_t             cfg_mirror = '{MIN_RANGE_RST, MAX_RANGE_RST, MARGIN_RST,
                                   ACCEPT_RST, LEARN_RST};

  pixel_t   pixel_q[$];
  verdict_t verdict_q[$];
  pixel_t   cur_pix;
  verdict_t want;

  int unsigned send_idle = 0;
  int unsigned recv_stall = 0;
  int unsigned mismatches = 0;
  int unsigned pixels_sent = 0;
  int unsigned outside_sent = 0;
  int unsigned fg_seen = 0;
  int unsigned settings_used = 0;
  int unsigned idle_cycles = 0;
  int unsigned hold_left = 0;
  logic        hold_req = 1'b0;
  logic        hold_done = 1'b0;
  logic [IDX_W-1:0] last_index = '0;
  int unsigned pool [8] = '{0, 1, 2, 3, 4, 5, 307198, 307199};

  logic [DEPTH_W-1:0] min_tab    [PHASES] = '{16'd500, 16'd0, 16'd0, 16'd65535,
                                              16'd1000, 16'd0, 16'd300, 16'd2000};
  logic [DEPTH_W-1:0] max_tab    [PHASES] = '{16'd4500, 16'd65535, 16'd65535, 16'd0,
                                              16'd3000, 16'd0, 16'd8000, 16'd2500};
  logic [DEPTH_W-1:0] margin_tab [PHASES] = '{16'd100, 16'd0, 16'd65535, 16'd0,
                                              16'd50, 16'd10, 16'd200, 16'd1};
  logic [DEPTH_W-1:0] accept_tab [PHASES] = '{16'd30, 16'd1, 16'd65535, 16'd0,
                                              16'd2, 16'd3, 16'd5, 16'd65535};
  logic [DEPTH_W-1:0] learn_tab  [PHASES] = '{16'd30, 16'd1, 16'd65535, 16'd0,
                                              16'd2, 16'd3, 16'd5, 16'd1};
  int unsigned        send_tab   [4] = '{0, 50, 0, 12};
  int unsigned        recv_tab   [4] = '{0, 0, 50, 12};

  task automatic report_mismatch(string msg);
    if (mismatches < 30) $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  function automatic void classify_pixel(pixel_t p);
    bit [DEPTH_W-1:0] bg;
    bit [DEPTH_W-1:0] pend;
    bit [DEPTH_W:0]   near_sum;
    bit               fg;
    bit               was_ready;
    verdict_t         res;
    was_ready = mirror_ready;
    fg = 1'b0;
    near_sum = {1'b0, p.depth} + {1'b0, cfg_mirror.margin};
    pixels_sent++;
    if (p.index < PIXEL_COUNT) begin
      bg = bg_mem[p.index];
      pend = pend_mem[p.index];
      if (!was_ready) begin
        if (p.depth != 0 && p.depth > bg) bg = p.depth;
      end else begin
        if (p.depth != 0) begin
          if (near_sum >= {1'b0, bg} || bg == 0) begin
            if (p.depth > bg) bg = p.depth;
            if (pend != 0) pend = pend - 1'b1;
          end else begin
            if (pend != COUNT_MAX) pend = pend + 1'b1;
            if (pend >= cfg_mirror.accept_frames) begin
              bg = p.depth;
              pend = '0;
            end
          end
        end
        fg = p.depth >= cfg_mirror.min_range_mm && p.depth <= cfg_mirror.max_range_mm &&
             bg != 0 && near_sum < {1'b0, bg};
      end
      bg_mem[p.index] = bg;
      pend_mem[p.index] = pend;
    end else begin
      outside_sent++;
    end
    if (!was_ready && p.last) begin
      if (frames_learned != COUNT_MAX) frames_learned = frames_learned + 1'b1;
      if (frames_learned >= cfg_mirror.learn_frames) mirror_ready = 1'b1;
    end
    res = '{fg, was_ready};
    verdict_q.insert(verdict_q.size(), res);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) classify_pixel(cur_pix);
      if (!in_tvalid || in_tready) begin
        if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle) begin
          cur_pix = pixel_q[0];
          pixel_q.delete(0);
          in_tvalid <= 1'b1;
          in_tdata <= {5'd0, cur_pix.index, cur_pix.depth};
          in_tlast <= cur_pix.last;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (verdict_q.size() == 0) begin
          report_mismatch("result item arrived with nothing expected");
        end else begin
          want = verdict_q[0];
          verdict_q.delete(0);
          if (want.fg) fg_seen++;
          if (out_tdata !== {7'd0, want.fg})
            report_mismatch($sformatf("out_tdata %h, expected foreground %0b",
                                      out_tdata, want.fg));
          if (out_tuser !== want.ready)
            report_mismatch($sformatf("out_tuser %b, expected model ready %0b",
                                      out_tuser, want.ready));
        end
      end
      out_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall);
    end
  end

  // Long receiver hold-off, started once on request.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no item moved for %0d cycles", idle_cycles);
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DEPTH_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    unique case (idx)
      REG_MIN_RANGE: cfg_mirror.min_range_mm = data;
      REG_MAX_RANGE: cfg_mirror.max_range_mm = data;
      REG_MARGIN:    cfg_mirror.margin = data;
      REG_ACCEPT:    cfg_mirror.accept_frames = data;
      REG_LEARN:     cfg_mirror.learn_frames = data;
      default: ;
    endcase
  endtask

  task automatic push_pixel(int unsigned depth, int unsigned index, bit last);
    pixel_t p;
    p.depth = depth[DEPTH_W-1:0];
    p.index = index[IDX_W-1:0];
    p.last = last;
    pixel_q.insert(pixel_q.size(), p);
  endtask

  function automatic pixel_t random_pixel();
    pixel_t      p;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 15) p.index = last_index;
    else if (pick < 75) p.index = IDX_W'(pool[3'($urandom_range(7))]);
    else if (pick < 88) p.index = IDX_W'($urandom_range(PIXEL_COUNT - 1));
    else p.index = IDX_W'($urandom_range(524287, PIXEL_COUNT));
    case ($urandom_range(9))
      0:       p.depth = '0;
      1, 2:    p.depth = DEPTH_W'($urandom_range(65535));
      3, 4, 5: p.depth = DEPTH_W'($urandom_range(2500, 500));
      default: p.depth = DEPTH_W'($urandom_range(6000, 2600));
    endcase
    p.last = ($urandom_range(19) == 0);
    last_index = p.index;
    return p;
  endfunction

  // Lets queued items go out under the given idling and waits for every result.
  task automatic run_items(int unsigned send_pct, int unsigned recv_pct);
    send_idle = send_pct;
    recv_stall = recv_pct;
    while (pixel_q.size() != 0 || in_tvalid || verdict_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Learning: zero and full-scale depths, farther and nearer readings,
    // top index, indexes outside the frame carrying frame marks.
    write_reg(REG_LEARN, 16'hFFFF);
    settings_used++;
    push_pixel(0, 0, 1'b0);
    push_pixel(65535, 1, 1'b0);
    push_pixel(1000, 2, 1'b0);
    push_pixel(800, 2, 1'b0);
    push_pixel(1200, 2, 1'b0);
    push_pixel(2000, 307199, 1'b0);
    push_pixel(3000, 307200, 1'b1);
    push_pixel(65535, 524287, 1'b1);
    run_items(0, 0);
    repeat (60) pixel_q.insert(pixel_q.size(), random_pixel());
    run_items(12, 12);

    // A learn limit of zero ends learning on the next frame mark.
    write_reg(REG_LEARN, 16'd0);
    push_pixel(1500, 3, 1'b1);
    run_items(0, 0);

    // Ready: edge of the margin, counting up to the accept limit, adoption of
    // a farther reading, zero depths classified with a zero minimum range,
    // a pixel outside the frame and a pixel with empty background.
    write_reg(REG_ACCEPT, 16'd2);
    write_reg(REG_MIN_RANGE, 16'd0);
    settings_used++;
    push_pixel(1100, 2, 1'b0);
    push_pixel(1099, 2, 1'b0);
    push_pixel(1000, 2, 1'b1);
    push_pixel(5000, 2, 1'b0);
    push_pixel(0, 2, 1'b0);
    push_pixel(0, 3, 1'b0);
    push_pixel(700, 307200, 1'b0);
    push_pixel(65535, 1, 1'b0);
    push_pixel(100, 4, 1'b0);
    run_items(0, 0);

    for (int p = 0; p < PHASES; p++) begin
      write_reg(REG_MIN_RANGE, min_tab[3'(p)]);
      write_reg(REG_MAX_RANGE, max_tab[3'(p)]);
      write_reg(REG_MARGIN, margin_tab[3'(p)]);
      write_reg(REG_ACCEPT, accept_tab[3'(p)]);
      write_reg(REG_LEARN, learn_tab[3'(p)]);
      settings_used++;
      if (p == 4) hold_req <= 1'b1;
      repeat (PHASE_ITEMS) pixel_q.insert(pixel_q.size(), random_pixel());
      run_items(send_tab[2'(p)], recv_tab[2'(p)]);
    end

    repeat (10) @(posedge clk);
    $display("Run covered %0d pixel items, %0d outside the frame, under %0d register settings.",
             pixels_sent, outside_sent, settings_used);
    $display("%0d foreground results seen; learning ended after %0d frame marks.",
             fg_seen, frames_learned);
    if (mismatches == 0 && verdict_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches, %0d results still expected", mismatches, verdict_q.size());
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
